/* sv/tlt_pkg.sv */
package tlt_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int WORD_WIDTH  = 32;
    localparam int DIM_W       = 13;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = ADDR_W;
    localparam int POS_W       = IDX_W + 1;
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int PAIR_W      = 2 * DIM_W;
    localparam int SIZE_W      = 3 * DIM_W;
    localparam int OFFSET_W    = IDX_W + DIM_W;
    localparam int SCALED_W    = IDX_W + PAIR_W;
    localparam int SUM_W       = SCALED_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION = 2'd0,
        REG_CHANNELS  = 2'd1,
        REG_HEIGHT    = 2'd2,
        REG_WIDTH     = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_PULL = 1'b1
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_LOADED = 2'd1,
        STATUS_SIZE_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic stage1;
        logic stage2;
        logic execute;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic is_pull;
        logic out_free;
    } sts_t;

endpackage

/* sv/tlt_req_if.sv */
interface tlt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [tlt_pkg::WORD_WIDTH-1:0] data_word;

    modport source (output valid, output mode, output data_word, input ready);
    modport sink (input valid, input mode, input data_word, output ready);
endinterface

/* sv/tlt_rsp_if.sv */
interface tlt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tlt_pkg::WORD_WIDTH-1:0] out_word;
    logic                           last;
    logic [tlt_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output out_word, output last, output status, input ready);
    modport sink (input valid, input out_word, input last, input status, output ready);
endinterface

/* sv/tlt_cfg_if.sv */
interface tlt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tlt_pkg::CFG_IDX_W-1:0] index;
    logic [tlt_pkg::DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/tensor_layout_transpose.sv */
// Buffers one batch-1 tensor and returns it in the other layout.
// The request channel carries transactions with mode and data_word. A load transaction
// stores the next word in source order; a pull transaction returns the next word in
// destination order on the response channel, with last set on the final word and
// status telling ok, not loaded or size error. Loads produce no response.
// The cfg channel writes direction, channels, height and width by index; it is ready
// only while no request transaction is in progress.
// One transaction is handled at a time. Each transaction passes through capture, two
// multiply stages for the tensor size and the read address, and an execute step for the
// decision and the memory access; a pull then adds a push step that registers the
// response, and it waits in that step while the output register is still full.
// Reset clears the load count and the position counters and sets direction to 0 and
// all dimensions to 1; the element memory keeps no reset value.
// When the receiver stalls, a finished response waits in the output register and the
// block holds the next pull until it has been taken; request ready stays low meanwhile.
module tensor_layout_transpose (
    input logic       clk,
    input logic       rst_n,
    tlt_req_if.sink   request,
    tlt_rsp_if.source response,
    tlt_cfg_if.sink   cfg
);

    tlt_pkg::cmd_t cmd;
    tlt_pkg::sts_t sts;

    tlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .cfg_ready (cfg.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tlt_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (request.mode),
        .data_word (request.data_word),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .out_word  (response.out_word),
        .last      (response.last),
        .status    (response.status)
    );

endmodule

/* sv/tlt_ram.sv */
module tlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/tlt_ctrl.sv */
module tlt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          cfg_ready,
    output tlt_pkg::cmd_t cmd,
    input  tlt_pkg::sts_t sts
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_MUL2 = 5'b00100,
        S_EXEC = 5'b01000,
        S_PUSH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        cfg_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cfg_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.stage1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.stage2 = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = sts.is_pull ? S_PUSH : S_IDLE;
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/tlt_dpath.sv */
module tlt_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tlt_pkg::cmd_t                    cmd,
    output tlt_pkg::sts_t                    sts,
    input  logic                             mode,
    input  logic [tlt_pkg::WORD_WIDTH-1:0]   data_word,
    input  logic                             cfg_we,
    input  logic [tlt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlt_pkg::DIM_W-1:0]        cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tlt_pkg::WORD_WIDTH-1:0]   out_word,
    output logic                             last,
    output logic [tlt_pkg::STATUS_W-1:0]     status
);

    logic                           direction_reg;
    logic [tlt_pkg::DIM_W-1:0]      channels_reg;
    logic [tlt_pkg::DIM_W-1:0]      height_reg;
    logic [tlt_pkg::DIM_W-1:0]      width_reg;

    logic                           mode_reg;
    logic [tlt_pkg::WORD_WIDTH-1:0] word_reg;

    logic [tlt_pkg::COUNT_W-1:0]    count_reg;
    logic [tlt_pkg::COUNT_W-1:0]    count_next;
    logic [tlt_pkg::IDX_W-1:0]      outer_reg;
    logic [tlt_pkg::IDX_W-1:0]      outer_next;
    logic [tlt_pkg::IDX_W-1:0]      middle_reg;
    logic [tlt_pkg::IDX_W-1:0]      middle_next;
    logic [tlt_pkg::IDX_W-1:0]      inner_reg;
    logic [tlt_pkg::IDX_W-1:0]      inner_next;

    logic [tlt_pkg::PAIR_W-1:0]     ch_prod_reg;
    logic [tlt_pkg::PAIR_W-1:0]     plane_prod_reg;
    logic [tlt_pkg::OFFSET_W-1:0]   offset_reg;
    logic [tlt_pkg::SIZE_W-1:0]     size_reg;
    logic [tlt_pkg::SCALED_W-1:0]   scaled_reg;

    logic [tlt_pkg::STATUS_W-1:0]   pend_status_reg;
    logic                           pend_last_reg;
    logic                           pend_in_range_reg;

    logic                           out_valid_reg;
    logic [tlt_pkg::WORD_WIDTH-1:0] out_word_reg;
    logic                           last_reg;
    logic [tlt_pkg::STATUS_W-1:0]   status_reg;

    logic [tlt_pkg::IDX_W-1:0]      idx_scaled;
    logic [tlt_pkg::IDX_W-1:0]      idx_offset;
    logic [tlt_pkg::IDX_W-1:0]      idx_plain;
    logic [tlt_pkg::DIM_W-1:0]      dim_offset;
    logic [tlt_pkg::POS_W-1:0]      dim_outer;
    logic [tlt_pkg::POS_W-1:0]      dim_middle;
    logic [tlt_pkg::POS_W-1:0]      dim_inner;
    logic [tlt_pkg::POS_W-1:0]      outer_inc;
    logic [tlt_pkg::POS_W-1:0]      middle_inc;
    logic [tlt_pkg::POS_W-1:0]      inner_inc;
    logic [tlt_pkg::SUM_W-1:0]      addr_sum;
    logic                           size_bad;
    logic                           loaded;
    logic                           load_ok;
    logic                           is_last;
    logic                           pull_ok;
    logic                           ram_we;
    logic                           ram_re;
    logic [tlt_pkg::WORD_WIDTH-1:0] ram_q;

    always_comb
    begin
        if (direction_reg)
        begin
            idx_scaled = middle_reg;
            idx_offset = inner_reg;
            idx_plain  = outer_reg;
            dim_offset = channels_reg;
            dim_outer  = tlt_pkg::POS_W'(channels_reg);
            dim_middle = tlt_pkg::POS_W'(height_reg);
            dim_inner  = tlt_pkg::POS_W'(width_reg);
        end
        else
        begin
            idx_scaled = inner_reg;
            idx_offset = outer_reg;
            idx_plain  = middle_reg;
            dim_offset = width_reg;
            dim_outer  = tlt_pkg::POS_W'(height_reg);
            dim_middle = tlt_pkg::POS_W'(width_reg);
            dim_inner  = tlt_pkg::POS_W'(channels_reg);
        end
    end

    assign addr_sum = tlt_pkg::SUM_W'(scaled_reg) + tlt_pkg::SUM_W'(offset_reg)
                    + tlt_pkg::SUM_W'(idx_plain);

    assign size_bad = (channels_reg == '0) || (height_reg == '0) || (width_reg == '0)
                   || (size_reg > tlt_pkg::SIZE_W'(tlt_pkg::STORE_DEPTH));
    assign loaded   = tlt_pkg::SIZE_W'(count_reg) >= size_reg;
    assign load_ok  = (count_reg < tlt_pkg::COUNT_W'(tlt_pkg::STORE_DEPTH)) && !loaded;

    assign outer_inc  = tlt_pkg::POS_W'(outer_reg) + 1'b1;
    assign middle_inc = tlt_pkg::POS_W'(middle_reg) + 1'b1;
    assign inner_inc  = tlt_pkg::POS_W'(inner_reg) + 1'b1;
    assign is_last    = (outer_inc == dim_outer) && (middle_inc == dim_middle)
                     && (inner_inc == dim_inner);

    assign pull_ok = cmd.execute && (mode_reg == tlt_pkg::MODE_PULL) && !size_bad && loaded;
    assign ram_we  = cmd.execute && (mode_reg == tlt_pkg::MODE_LOAD) && load_ok;
    assign ram_re  = pull_ok;

    always_comb
    begin
        count_next  = count_reg;
        outer_next  = outer_reg;
        middle_next = middle_reg;
        inner_next  = inner_reg;
        if (ram_we)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pull_ok)
        begin
            if (is_last)
            begin
                count_next  = '0;
                outer_next  = '0;
                middle_next = '0;
                inner_next  = '0;
            end
            else if (inner_inc < dim_inner)
            begin
                inner_next = inner_inc[tlt_pkg::IDX_W-1:0];
            end
            else
            begin
                inner_next = '0;
                if (middle_inc < dim_middle)
                begin
                    middle_next = middle_inc[tlt_pkg::IDX_W-1:0];
                end
                else
                begin
                    middle_next = '0;
                    if (outer_inc < dim_outer)
                    begin
                        outer_next = outer_inc[tlt_pkg::IDX_W-1:0];
                    end
                    else
                    begin
                        outer_next = '0;
                    end
                end
            end
        end
    end

    tlt_ram #(
        .WIDTH (tlt_pkg::WORD_WIDTH),
        .DEPTH (tlt_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[tlt_pkg::ADDR_W-1:0]),
        .wr_data (word_reg),
        .rd_en   (ram_re),
        .rd_addr (addr_sum[tlt_pkg::ADDR_W-1:0]),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            channels_reg  <= tlt_pkg::DIM_W'(1);
            height_reg    <= tlt_pkg::DIM_W'(1);
            width_reg     <= tlt_pkg::DIM_W'(1);
            count_reg     <= '0;
            outer_reg     <= '0;
            middle_reg    <= '0;
            inner_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (tlt_pkg::cfg_index_t'(cfg_index))
                    tlt_pkg::REG_DIRECTION: direction_reg <= cfg_data[0];
                    tlt_pkg::REG_CHANNELS:  channels_reg  <= cfg_data;
                    tlt_pkg::REG_HEIGHT:    height_reg    <= cfg_data;
                    tlt_pkg::REG_WIDTH:     width_reg     <= cfg_data;
                    default:                direction_reg <= direction_reg;
                endcase
            end
            count_reg  <= count_next;
            outer_reg  <= outer_next;
            middle_reg <= middle_next;
            inner_reg  <= inner_next;
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            word_reg <= data_word;
        end
        if (cmd.stage1)
        begin
            ch_prod_reg    <= channels_reg * height_reg;
            plane_prod_reg <= direction_reg ? width_reg * channels_reg
                                            : height_reg * width_reg;
            offset_reg     <= idx_offset * dim_offset;
        end
        if (cmd.stage2)
        begin
            size_reg   <= ch_prod_reg * width_reg;
            scaled_reg <= idx_scaled * plane_prod_reg;
        end
        if (cmd.execute)
        begin
            pend_in_range_reg <= addr_sum < tlt_pkg::SUM_W'(tlt_pkg::STORE_DEPTH);
            pend_last_reg     <= 1'b0;
            if (size_bad)
            begin
                pend_status_reg <= tlt_pkg::STATUS_SIZE_ERROR;
            end
            else if (!loaded)
            begin
                pend_status_reg <= tlt_pkg::STATUS_NOT_LOADED;
            end
            else
            begin
                pend_status_reg <= tlt_pkg::STATUS_OK;
                pend_last_reg   <= is_last;
            end
        end
        if (cmd.push)
        begin
            out_word_reg <= ((pend_status_reg == tlt_pkg::STATUS_OK) && pend_in_range_reg)
                          ? ram_q : '0;
            last_reg     <= pend_last_reg;
            status_reg   <= pend_status_reg;
        end
    end

    assign sts.is_pull  = (mode_reg == tlt_pkg::MODE_PULL);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign last      = last_reg;
    assign status    = status_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int TIMEOUT_NS    = 20_000_000;

    typedef struct packed {
        logic [tlt_pkg::WORD_WIDTH-1:0] word;
        logic                           last;
        tlt_pkg::status_t               status;
    } result_t;

    logic clk;
    logic rst_n;

    tlt_req_if req_if();
    tlt_rsp_if rsp_if();
    tlt_cfg_if cfg_if();

    tensor_layout_transpose dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if),
        .cfg      (cfg_if)
    );

    logic [tlt_pkg::WORD_WIDTH-1:0] shadow_store [tlt_pkg::STORE_DEPTH];
    longint unsigned                held_words;
    longint unsigned                pos_outer;
    longint unsigned                pos_middle;
    longint unsigned                pos_inner;
    logic                           layout_dir;
    logic [tlt_pkg::DIM_W-1:0]      dim_c;
    logic [tlt_pkg::DIM_W-1:0]      dim_h;
    logic [tlt_pkg::DIM_W-1:0]      dim_w;
    bit                             tensor_done;
    tlt_pkg::status_t               last_pull_status;
    result_t                        awaited_words [$];
    int                             burst_left;
    int                             stim_count;
    int                             error_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic longint unsigned tensor_words();
        longint unsigned n;
        n = 64'(dim_c);
        n = n * dim_h * dim_w;
        return n;
    endfunction

    function automatic bit shape_bad();
        return dim_c == '0 || dim_h == '0 || dim_w == '0
            || tensor_words() > tlt_pkg::STORE_DEPTH;
    endfunction

    function automatic bit predict_load(logic [tlt_pkg::WORD_WIDTH-1:0] d);
        if (held_words < tlt_pkg::STORE_DEPTH && held_words < tensor_words())
        begin
            shadow_store[held_words[tlt_pkg::ADDR_W-1:0]] = d;
            held_words++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t predict_pull();
        result_t         r;
        longint unsigned addr;
        longint unsigned d_outer;
        longint unsigned d_middle;
        longint unsigned d_inner;
        bit              at_end;
        r.word = '0;
        r.last = 1'b0;
        r.status = tlt_pkg::STATUS_OK;
        tensor_done = 1'b0;
        if (shape_bad())
            r.status = tlt_pkg::STATUS_SIZE_ERROR;
        else if (held_words < tensor_words())
            r.status = tlt_pkg::STATUS_NOT_LOADED;
        last_pull_status = r.status;
        if (r.status != tlt_pkg::STATUS_OK)
            return r;
        if (layout_dir == 1'b0)
        begin
            d_outer = 64'(dim_h);
            d_middle = 64'(dim_w);
            d_inner = 64'(dim_c);
            addr = pos_inner * dim_h * dim_w + pos_outer * dim_w + pos_middle;
        end
        else
        begin
            d_outer = 64'(dim_c);
            d_middle = 64'(dim_h);
            d_inner = 64'(dim_w);
            addr = pos_middle * dim_w * dim_c + pos_inner * dim_c + pos_outer;
        end
        if (addr < tlt_pkg::STORE_DEPTH)
            r.word = shadow_store[addr[tlt_pkg::ADDR_W-1:0]];
        at_end = pos_outer + 1 == d_outer && pos_middle + 1 == d_middle &&
                 pos_inner + 1 == d_inner;
        if (at_end)
        begin
            pos_outer = 0;
            pos_middle = 0;
            pos_inner = 0;
            held_words = 0;
        end
        else
        begin
            pos_inner++;
            if (pos_inner >= d_inner)
            begin
                pos_inner = 0;
                pos_middle++;
                if (pos_middle >= d_middle)
                begin
                    pos_middle = 0;
                    pos_outer++;
                    if (pos_outer >= d_outer)
                        pos_outer = 0;
                end
            end
        end
        r.last = at_end;
        tensor_done = at_end;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_response();
        result_t want;
        if (awaited_words.size() == 0)
        begin
            report_mismatch("response transaction with no pull outstanding");
            return;
        end
        want = awaited_words.pop_front();
        if (rsp_if.out_word !== want.word)
            report_mismatch($sformatf("out_word %h, expected %h", rsp_if.out_word, want.word));
        if (rsp_if.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", rsp_if.last, want.last));
        if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_response();
    end

    initial
    begin
        logic [15:0] ready_pattern;
        int          pattern_left;
        rsp_if.ready <= 1'b0;
        ready_pattern = '1;
        pattern_left = 0;
        forever
        begin
            @(posedge clk);
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: ready_pattern = '1;
                    1: ready_pattern = 16'($urandom) | 16'h0001;
                    2: ready_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
                    default: ready_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            pattern_left--;
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            rsp_if.ready <= ready_pattern[0] | (ready_pattern == '0);
        end
    end

    task automatic send_item(tlt_pkg::mode_t m, logic [tlt_pkg::WORD_WIDTH-1:0] d);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.mode <= m;
        req_if.data_word <= d;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        if (m == tlt_pkg::MODE_LOAD)
        begin
            if (predict_load(d))
                stim_count++;
        end
        else
        begin
            awaited_words.push_back(predict_pull());
            stim_count++;
        end
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(tlt_pkg::cfg_index_t idx, logic [tlt_pkg::DIM_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            tlt_pkg::REG_DIRECTION: layout_dir = val[0];
            tlt_pkg::REG_CHANNELS:  dim_c = val;
            tlt_pkg::REG_HEIGHT:    dim_h = val;
            tlt_pkg::REG_WIDTH:     dim_w = val;
            default: ;
        endcase
    endtask

    task automatic program_shape(logic dir, logic [tlt_pkg::DIM_W-1:0] c,
                                 logic [tlt_pkg::DIM_W-1:0] h,
                                 logic [tlt_pkg::DIM_W-1:0] w);
        logic [tlt_pkg::DIM_W-2:0] pad;
        pad = (tlt_pkg::DIM_W-1)'($urandom);
        wait_idle();
        write_register(tlt_pkg::REG_DIRECTION, {pad, dir});
        write_register(tlt_pkg::REG_CHANNELS, c);
        write_register(tlt_pkg::REG_HEIGHT, h);
        write_register(tlt_pkg::REG_WIDTH, w);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic fill_tensor(int early_pull_odds);
        while (held_words < tensor_words() && held_words < tlt_pkg::STORE_DEPTH)
        begin
            if (early_pull_odds != 0 && $urandom_range(1, early_pull_odds) == 1)
                send_item(tlt_pkg::MODE_PULL, $urandom);
            else
                send_item(tlt_pkg::MODE_LOAD, $urandom);
        end
    endtask

    task automatic pull_to_end();
        do
            send_item(tlt_pkg::MODE_PULL, $urandom);
        while (!tensor_done && last_pull_status == tlt_pkg::STATUS_OK);
    endtask

    task automatic test_stale_position();
        program_shape(1'b0, 1, 1, 66);
        fill_tensor(0);
        repeat (63) send_item(tlt_pkg::MODE_PULL, $urandom);
        // With the new shape the stale position first points past the end of the store,
        // then the walk wraps back into the loaded words.
        program_shape(1'b1, 66, 1, 1);
        pull_to_end();
    endtask

    task automatic test_directed();
        program_shape(1'b0, 4096, 1, 1);
        send_item(tlt_pkg::MODE_PULL, '1);
        send_item(tlt_pkg::MODE_LOAD, '1);
        send_item(tlt_pkg::MODE_PULL, '0);
        program_shape(1'b1, 4096, 2, 1);
        send_item(tlt_pkg::MODE_PULL, $urandom);
        send_item(tlt_pkg::MODE_LOAD, '0);
        send_item(tlt_pkg::MODE_PULL, $urandom);
        program_shape(1'b0, 0, 1, 1);
        send_item(tlt_pkg::MODE_PULL, $urandom);
        program_shape(1'b1, 8191, 8191, 8191);
        send_item(tlt_pkg::MODE_PULL, $urandom);
        program_shape(1'b1, 1, 1, 2);
        send_item(tlt_pkg::MODE_LOAD, 32'h5a5a_a5a5);
        pull_to_end();
        program_shape(1'b0, 1, 4096, 1);
        send_item(tlt_pkg::MODE_PULL, $urandom);
        program_shape(1'b1, 1, 1, 4096);
        send_item(tlt_pkg::MODE_PULL, $urandom);
        program_shape(1'b0, 2, 2, 1);
        fill_tensor(0);
        send_item(tlt_pkg::MODE_PULL, $urandom);
        program_shape(1'b1, 1, 2, 2);
        pull_to_end();
    endtask

    task automatic test_random();
        logic [tlt_pkg::DIM_W-1:0] c;
        logic [tlt_pkg::DIM_W-1:0] h;
        logic [tlt_pkg::DIM_W-1:0] w;
        logic                      dir;
        int                        pick;
        int                        words;
        stim_count = 0;
        while (stim_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            dir = 1'($urandom_range(0, 1));
            if (pick == 0)
            begin
                program_shape(dir, tlt_pkg::DIM_W'($urandom_range(0, 8191)),
                              tlt_pkg::DIM_W'($urandom_range(0, 8191)),
                              tlt_pkg::DIM_W'($urandom_range(0, 8191)));
                repeat ($urandom_range(2, 6))
                    send_item(($urandom_range(0, 1) == 0) ? tlt_pkg::MODE_LOAD
                                                          : tlt_pkg::MODE_PULL, $urandom);
            end
            else
            begin
                c = tlt_pkg::DIM_W'($urandom_range(1, 4));
                h = tlt_pkg::DIM_W'($urandom_range(1, 4));
                w = tlt_pkg::DIM_W'($urandom_range(1, 4));
                if ($urandom_range(0, 5) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: c = tlt_pkg::DIM_W'($urandom_range(1, 32));
                        1: h = tlt_pkg::DIM_W'($urandom_range(1, 32));
                        default: w = tlt_pkg::DIM_W'($urandom_range(1, 32));
                    endcase
                end
                words = int'(c) * int'(h) * int'(w);
                program_shape(dir, c, h, w);
                fill_tensor(16);
                if ($urandom_range(0, 3) == 0)
                    send_item(tlt_pkg::MODE_LOAD, $urandom);
                if (pick == 1 && words > 1 && held_words >= words)
                begin
                    repeat ($urandom_range(1, words - 1))
                        send_item(tlt_pkg::MODE_PULL, $urandom);
                    // The opposite layout keeps every position within the loaded words.
                    if (dir == 1'b0)
                        program_shape(1'b1, h, w, c);
                    else
                        program_shape(1'b0, w, c, h);
                end
                pull_to_end();
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.mode <= tlt_pkg::MODE_LOAD;
        req_if.data_word <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= tlt_pkg::REG_DIRECTION;
        cfg_if.data <= '0;
        held_words = 0;
        pos_outer = 0;
        pos_middle = 0;
        pos_inner = 0;
        layout_dir = 1'b0;
        dim_c = 1;
        dim_h = 1;
        dim_w = 1;
        tensor_done = 1'b0;
        last_pull_status = tlt_pkg::STATUS_OK;
        burst_left = 0;
        stim_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stale_position();
        test_directed();
        test_random();
        wait_idle();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
